>>> hw/rtl/hsv_quantized_color_histogram_unit_defines.svh
// ----------------------------------------------------------------------------
// HSV histogram assertion macros
// Concurrent assertion wrappers used by the histogram top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef HSV_QUANTIZED_COLOR_HISTOGRAM_UNIT_DEFINES_SVH
`define HSV_QUANTIZED_COLOR_HISTOGRAM_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define HQCH_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must be followed by an expression in the next cycle.
`define HQCH_ASSERT_NEXT(lbl, clk, rst_n, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);
`else
`define HQCH_ASSERT(lbl, clk, rst_n, prop, msg)
`define HQCH_ASSERT_NEXT(lbl, clk, rst_n, cond, expr, msg)
`endif

`endif

>>> hw/rtl/hqch_pkg.sv
// ----------------------------------------------------------------------------
// HSV histogram package
// Field widths, operation codes, bin limits and quantizer functions.
// ----------------------------------------------------------------------------
`default_nettype none

package hqch_pkg;

    // Defaults for the top-level parameters.
    localparam int COUNT_BITS_DEF = 24;
    localparam int BIN_COUNT_DEF  = 256;

    // Widths of the stream fields.
    localparam int OP_BITS    = 2;
    localparam int PIX_BITS   = 8;
    localparam int CODE_BITS  = 8;
    localparam int OUT_CNT_W  = 24;
    localparam int SHARE_BITS = 16;

    // Quotient bits of the share divider: one integer bit for saturation.
    localparam int DIV_STEPS    = SHARE_BITS + 1;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

    // Operation codes carried in the input tuser.
    localparam logic [OP_BITS-1:0] OP_ACCUM = 2'd0;
    localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_BITS-1:0] OP_READ  = 2'd2;

    // Inclusive upper limits on the doubled hue, one per hue bin.
    localparam int HUE_BINS = 16;
    localparam logic [8:0] HUE_LIMIT [HUE_BINS] = '{
        9'd15,  9'd25,  9'd45,  9'd55,  9'd80,  9'd108, 9'd140, 9'd165,
        9'd190, 9'd220, 9'd255, 9'd275, 9'd290, 9'd316, 9'd330, 9'd345
    };

    // Inclusive upper limits of the saturation and value levels.
    localparam logic [7:0] LEVEL_LIM0 = 8'd38;
    localparam logic [7:0] LEVEL_LIM1 = 8'd102;
    localparam logic [7:0] LEVEL_LIM2 = 8'd191;

    // Hue bin of a half-degree hue; red above the top limit wraps to bin 0.
    function automatic logic [3:0] hue_bin(input logic [PIX_BITS-1:0] hue);
        logic [8:0] d;
        logic [3:0] bin;
        d   = {hue, 1'b0};
        bin = '0;
        for (int k = HUE_BINS - 1; k >= 0; k--) begin
            if (d <= HUE_LIMIT[k]) begin
                bin = 4'(k);
            end
        end
        return bin;
    endfunction

    // Level bin of a saturation or value sample.
    function automatic logic [1:0] level_bin(input logic [PIX_BITS-1:0] x);
        logic [1:0] bin;
        if (x <= LEVEL_LIM0) begin
            bin = 2'd0;
        end else if (x <= LEVEL_LIM1) begin
            bin = 2'd1;
        end else if (x <= LEVEL_LIM2) begin
            bin = 2'd2;
        end else begin
            bin = 2'd3;
        end
        return bin;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/hqch_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module hqch_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hw/rtl/hsv_quantized_color_histogram_unit.sv
// ----------------------------------------------------------------------------
// HSV quantized color histogram
// Counts HSV pixels in 16x4x4 bins and reports bin counts and shares.
// ----------------------------------------------------------------------------
// Usage: operations enter on the s_axis channel, with the operation code in
// tuser and the pixel and bin index in tdata. Each transaction gives exactly
// one result transaction on m_axis.
// Steps of each operation, counted from acceptance to the result being ready:
//   accumulate  a read-modify-write through the count RAM: the registered
//               read, then the write back of the incremented count.
//   clear and the unused code  finish on acceptance.
//   read        the registered RAM read; if the total is not zero, the share is
//               then formed by a restoring divider, one quotient bit per cycle.
// One operation is in work at a time; the next is accepted once the current
// one has moved its result to the output register.
// Reset and clear drop the per-bin valid flags at once, so every bin reads as
// zero immediately; no clearing pass runs over the RAM.
// When m_axis stalls, the finished result waits in the output register and
// the block still accepts and computes the next operation, then holds that
// result until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hsv_quantized_color_histogram_unit_defines.svh"

module hsv_quantized_color_histogram_unit
    import hqch_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int BIN_COUNT  = BIN_COUNT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: hue [7:0], saturation [15:8], brightness [23:16], bin_index [31:24]
    input  wire logic [31:0] s_axis_tdata,
    // tuser: opcode [1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: pixel_bin [7:0], bin_count [31:8], bin_share [47:32],
    //        pixel_total [71:48]
    output logic [71:0]      m_axis_tdata
);

    localparam int BIN_BITS = $clog2(BIN_COUNT);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MOD  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state                  r_state, n_state;
    logic [OP_BITS-1:0]      r_op;
    logic [BIN_BITS-1:0]     r_idx;
    logic [BIN_COUNT-1:0]    r_valid;
    logic [COUNT_BITS-1:0]   r_total;
    logic [COUNT_BITS-1:0]   r_rd_count;
    logic [COUNT_BITS:0]     r_div_rem;
    logic [DIV_STEPS-1:0]    r_div_quo;
    logic [DIV_CNT_BITS-1:0] r_div_cnt;
    logic [CODE_BITS-1:0]    r_res_bin;
    logic [COUNT_BITS-1:0]   r_res_count;
    logic [SHARE_BITS-1:0]   r_res_share;
    logic [COUNT_BITS-1:0]   r_res_total;
    logic                    r_out_valid;
    logic [71:0]             r_out_data;

    logic [OP_BITS-1:0]      w_in_op;
    logic [PIX_BITS-1:0]     w_hue, w_sat, w_val, w_rd_index;
    logic [BIN_BITS-1:0]     w_pix_bin, w_in_idx;
    logic                    w_in_acc;
    logic                    w_slot_free;
    logic [COUNT_BITS-1:0]   w_ram_rdata, w_cur, w_cur_inc, w_total_inc;
    logic                    w_ram_we;
    logic                    w_fin, w_div_load;
    logic [CODE_BITS-1:0]    w_fin_bin;
    logic [COUNT_BITS-1:0]   w_fin_count, w_fin_total;
    logic [SHARE_BITS-1:0]   w_fin_share;
    logic                    w_div_ge;
    logic [COUNT_BITS:0]     w_div_diff;
    logic [DIV_STEPS-1:0]    w_div_q;
    logic [SHARE_BITS-1:0]   w_div_share;

    // Input fields and handshake.
    assign w_in_op    = s_axis_tuser;
    assign w_hue      = s_axis_tdata[7:0];
    assign w_sat      = s_axis_tdata[15:8];
    assign w_val      = s_axis_tdata[23:16];
    assign w_rd_index = s_axis_tdata[31:24];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_slot_free   = !r_out_valid || m_axis_tready;

    // Bin code of the incoming pixel, and the RAM address to read.
    assign w_pix_bin = BIN_BITS'({hue_bin(w_hue), level_bin(w_sat), level_bin(w_val)});
    assign w_in_idx  = (w_in_op == OP_READ) ? BIN_BITS'(w_rd_index) : w_pix_bin;

    // Count store: a bin that has not been written since clear reads as zero.
    hqch_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (BIN_COUNT)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_idx),
        .i_wdata (w_cur_inc),
        .i_raddr (w_in_idx),
        .o_rdata (w_ram_rdata)
    );

    assign w_cur       = r_valid[r_idx] ? w_ram_rdata : '0;
    assign w_cur_inc   = (&w_cur) ? w_cur : w_cur + COUNT_BITS'(1);
    assign w_total_inc = (&r_total) ? r_total : r_total + COUNT_BITS'(1);

    // One restoring division step on count * 2^16 / total.
    assign w_div_ge    = (r_div_rem >= {1'b0, r_total});
    assign w_div_diff  = w_div_ge ? (r_div_rem - {1'b0, r_total}) : r_div_rem;
    assign w_div_q     = {r_div_quo[DIV_STEPS-2:0], w_div_ge};
    assign w_div_share = w_div_q[DIV_STEPS-1] ? '1 : w_div_q[SHARE_BITS-1:0];

    // Sequencer and result selection.
    always_comb begin
        n_state     = r_state;
        w_fin       = 1'b0;
        w_fin_bin   = '0;
        w_fin_count = '0;
        w_fin_share = '0;
        w_fin_total = r_total;
        w_div_load  = 1'b0;
        w_ram_we    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    case (w_in_op)
                        OP_ACCUM: n_state = S_MOD;
                        OP_READ:  n_state = S_MOD;
                        OP_CLEAR: begin
                            w_fin       = 1'b1;
                            w_fin_total = '0;
                        end
                        default: w_fin = 1'b1;
                    endcase
                end
            end
            S_MOD: begin
                if (r_op == OP_ACCUM) begin
                    w_ram_we    = 1'b1;
                    w_fin       = 1'b1;
                    w_fin_bin   = CODE_BITS'(r_idx);
                    w_fin_total = w_total_inc;
                end else if (r_total == '0) begin
                    w_fin       = 1'b1;
                    w_fin_count = w_cur;
                end else begin
                    w_div_load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                if (r_div_cnt == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
                    w_fin       = 1'b1;
                    w_fin_count = r_rd_count;
                    w_fin_share = w_div_share;
                end
            end
            S_DONE: begin
                w_fin       = 1'b1;
                w_fin_bin   = r_res_bin;
                w_fin_count = r_res_count;
                w_fin_share = r_res_share;
                w_fin_total = r_res_total;
            end
            default: n_state = S_IDLE;
        endcase
        if (w_fin) begin
            n_state = w_slot_free ? S_IDLE : S_DONE;
        end
    end

    // Control state, total and valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            if (w_in_acc && (w_in_op == OP_CLEAR)) begin
                r_valid <= '0;
                r_total <= '0;
            end else if (w_ram_we) begin
                r_valid[r_idx] <= 1'b1;
                r_total        <= w_total_inc;
            end
        end
    end

    // Captured operation and divider datapath.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op  <= w_in_op;
            r_idx <= w_in_idx;
        end
        if (w_div_load) begin
            r_rd_count <= w_cur;
            r_div_rem  <= {1'b0, w_cur};
            r_div_quo  <= '0;
            r_div_cnt  <= '0;
        end else if (r_state == S_DIV) begin
            r_div_rem <= {w_div_diff[COUNT_BITS-1:0], 1'b0};
            r_div_quo <= w_div_q;
            r_div_cnt <= r_div_cnt + DIV_CNT_BITS'(1);
        end
    end

    // Hold register for a result that finds the output register busy.
    always_ff @(posedge i_clk) begin
        if (w_fin && !w_slot_free) begin
            r_res_bin   <= w_fin_bin;
            r_res_count <= w_fin_count;
            r_res_share <= w_fin_share;
            r_res_total <= w_fin_total;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fin && w_slot_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin && w_slot_free) begin
            r_out_data <= {OUT_CNT_W'(w_fin_total), w_fin_share,
                           OUT_CNT_W'(w_fin_count), w_fin_bin};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // A bin can never hold more pixels than the total.
    `HQCH_ASSERT(a_count_le_total, i_clk, i_rst_n, ((r_state == S_MOD) && (r_op == OP_READ)) |-> (w_cur <= r_total), "bin count exceeds pixel total")
    // A clear leaves the total at zero.
    `HQCH_ASSERT_NEXT(a_clear_total, i_clk, i_rst_n, w_in_acc && (w_in_op == OP_CLEAR), r_total == '0, "total not zero after clear")
    // The divider never runs past its last quotient bit.
    `HQCH_ASSERT(a_div_bound, i_clk, i_rst_n, (r_state == S_DIV) |-> (r_div_cnt < DIV_CNT_BITS'(DIV_STEPS)), "divider step count overrun")
    // A pending result waits only while the output register is occupied.
    `HQCH_ASSERT(a_done_busy, i_clk, i_rst_n, (r_state == S_DONE) |-> r_out_valid, "held result with free output register")

endmodule

`default_nettype wire
